[sv/nvcrw_pkg.sv]
// Shared types and constants for the nonvolatile changed-run writer.
`timescale 1ns / 1ps

package nvcrw_pkg;

   typedef struct packed {
      logic [15:0] start_address;
      logic [7:0]  stored_byte;
      logic [7:0]  wanted_byte;
      logic        clear_mode;
      logic [16:0] request_length;
      logic        stage_only;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] write_address;
      logic [16:0] write_length;
      logic        write_stage_only;
      logic [15:0] changed_address;
      logic [16:0] changed_length;
      logic [16:0] bytes_written;
      logic [15:0] write_count;
      logic [2:0]  profile_flags;
      logic        last_result;
   } rsp_type;

   // Up to two result words produced by one input word, packed from the front.
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } push_type;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [2:0] FLAG_OPTIMIZED = 3'h1;
   localparam logic [2:0] FLAG_RESET     = 3'h2;
   localparam logic [2:0] FLAG_TRUNCATED = 3'h4;

   localparam logic [15:0] POSITION_LIMIT = 16'hFFFF;
   localparam logic [16:0] WRITTEN_LIMIT  = 17'h1FFFF;
   localparam logic [15:0] COUNT_LIMIT    = 16'hFFFF;

   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_CNT_BITS-1:0] RSP_ROOM_LIMIT = RSP_CNT_BITS'(RSP_DEPTH - 2);

endpackage

[sv/nvcrw_core.sv]
// Run detection state and per-word result generation.
`timescale 1ns / 1ps

module nvcrw_core #(
   parameter int CHUNK_BYTES  = 64,
   parameter int ADDRESS_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  nvcrw_pkg::req_type item,
   output nvcrw_pkg::push_type push
);

   localparam logic [15:0] ADDR_MASK = 16'((17'd1 << ADDRESS_BITS) - 17'd1);
   localparam logic [16:0] CHUNK_LEN = 17'(CHUNK_BYTES);

   logic [15:0] position_ff, position_in;
   logic        in_run_ff, in_run_in;
   logic [15:0] run_begin_ff, run_begin_in;
   logic [15:0] first_changed_ff, first_changed_in;
   logic [16:0] end_changed_ff, end_changed_in;
   logic        any_changed_ff, any_changed_in;
   logic [16:0] written_total_ff, written_total_in;
   logic [15:0] command_total_ff, command_total_in;

   logic        diff;
   logic [16:0] pos_wide;
   logic [16:0] pos_plus;
   logic [15:0] begin_eff;
   logic [16:0] len_inc;
   logic [16:0] len_gap;
   logic        chunk_done;
   logic        run_open;
   logic        write_fire;
   logic [16:0] write_len;
   logic [17:0] written_sum;
   logic        any_eff;
   logic [15:0] first_eff;
   logic [16:0] end_eff;
   logic [2:0]  flags;
   nvcrw_pkg::rsp_type write_word;
   nvcrw_pkg::rsp_type summary_word;

   always_comb begin
      pos_wide  = {1'b0, position_ff};
      pos_plus  = pos_wide + 17'd1;
      diff      = item.clear_mode ? (item.stored_byte != 8'd0)
                                  : (item.stored_byte != item.wanted_byte);
      begin_eff = in_run_ff ? run_begin_ff : position_ff;
      len_inc   = pos_plus - {1'b0, begin_eff};
      len_gap   = pos_wide - {1'b0, run_begin_ff};
      chunk_done = diff && item.clear_mode && (len_inc >= CHUNK_LEN);
      run_open   = diff && !chunk_done;
      write_fire = diff ? (chunk_done || item.last_byte) : in_run_ff;
      write_len  = diff ? len_inc : len_gap;
      written_sum = {1'b0, written_total_ff} + (write_fire ? {1'b0, write_len} : 18'd0);

      any_eff   = any_changed_ff || diff;
      first_eff = any_changed_ff ? first_changed_ff : position_ff;
      end_eff   = diff ? pos_plus : end_changed_ff;

      written_total_in = written_sum[17] ? nvcrw_pkg::WRITTEN_LIMIT : written_sum[16:0];
      command_total_in = (write_fire && command_total_ff != nvcrw_pkg::COUNT_LIMIT)
                         ? command_total_ff + 16'd1 : command_total_ff;

      flags = nvcrw_pkg::FLAG_OPTIMIZED;
      if (item.clear_mode) begin
         flags = flags | nvcrw_pkg::FLAG_RESET;
      end else if (item.request_length != pos_plus) begin
         flags = flags | nvcrw_pkg::FLAG_TRUNCATED;
      end

      write_word                  = '0;
      write_word.kind             = nvcrw_pkg::KIND_WRITE;
      write_word.write_address    = (item.start_address + begin_eff) & ADDR_MASK;
      write_word.write_length     = write_len;
      write_word.write_stage_only = item.stage_only;
      write_word.last_result      = !item.last_byte;

      summary_word               = '0;
      summary_word.kind          = nvcrw_pkg::KIND_SUMMARY;
      summary_word.bytes_written = written_total_in;
      summary_word.write_count   = command_total_in;
      summary_word.profile_flags = flags;
      summary_word.last_result   = 1'b1;
      if (any_eff) begin
         summary_word.changed_address = (item.start_address + first_eff) & ADDR_MASK;
         summary_word.changed_length  = end_eff - {1'b0, first_eff};
      end

      push = '0;
      if (go) begin
         if (write_fire) begin
            push.first_valid  = 1'b1;
            push.first        = write_word;
            push.second_valid = item.last_byte;
            push.second       = summary_word;
         end else begin
            push.first_valid  = item.last_byte;
            push.first        = summary_word;
         end
      end

      if (item.last_byte) begin
         position_in      = '0;
         in_run_in        = 1'b0;
         run_begin_in     = '0;
         first_changed_in = '0;
         end_changed_in   = '0;
         any_changed_in   = 1'b0;
      end else begin
         position_in      = (position_ff != nvcrw_pkg::POSITION_LIMIT)
                            ? position_ff + 16'd1 : position_ff;
         in_run_in        = run_open;
         run_begin_in     = run_open ? begin_eff : run_begin_ff;
         first_changed_in = first_eff;
         end_changed_in   = end_eff;
         any_changed_in   = any_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         in_run_ff        <= 1'b0;
         run_begin_ff     <= '0;
         first_changed_ff <= '0;
         end_changed_ff   <= '0;
         any_changed_ff   <= 1'b0;
         written_total_ff <= '0;
         command_total_ff <= '0;
      end else if (go) begin
         position_ff      <= position_in;
         in_run_ff        <= in_run_in;
         run_begin_ff     <= run_begin_in;
         first_changed_ff <= first_changed_in;
         end_changed_ff   <= end_changed_in;
         any_changed_ff   <= any_changed_in;
         written_total_ff <= item.last_byte ? '0 : written_total_in;
         command_total_ff <= item.last_byte ? '0 : command_total_in;
      end
   end

   // An open run always contains a differing byte.
   assert property (@(posedge clock) disable iff (reset) in_run_ff |-> any_changed_ff)
      else $error("open run without any changed byte");

   // The final byte of an update returns the offset to the start.
   assert property (@(posedge clock) disable iff (reset)
      (go && item.last_byte) |=> (position_ff == 16'd0 && !in_run_ff))
      else $error("update state not cleared after final byte");

endmodule

[sv/nvcrw_rsp_fifo.sv]
// Small result queue that takes up to two words per cycle and sends one while the output is not stalled.
`timescale 1ns / 1ps

module nvcrw_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  nvcrw_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nvcrw_pkg::rsp_type  rsp_word
);

   nvcrw_pkg::rsp_type entries_ff [nvcrw_pkg::RSP_DEPTH];
   logic [nvcrw_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nvcrw_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nvcrw_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [nvcrw_pkg::RSP_CNT_BITS-1:0] push_count;
   logic                               pop;

   always_comb begin
      pop        = (count_ff != '0) && !rsp_stall;
      push_count = nvcrw_pkg::RSP_CNT_BITS'(push.first_valid)
                 + nvcrw_pkg::RSP_CNT_BITS'(push.second_valid);
      wr_ptr_in  = wr_ptr_ff + nvcrw_pkg::RSP_PTR_BITS'(push_count);
      rd_ptr_in  = rd_ptr_ff + nvcrw_pkg::RSP_PTR_BITS'(pop);
      count_in   = count_ff + push_count - nvcrw_pkg::RSP_CNT_BITS'(pop);
      room       = count_ff <= nvcrw_pkg::RSP_ROOM_LIMIT;
      rsp_valid  = count_ff != '0;
      rsp_word   = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entries_ff[wr_ptr_ff + nvcrw_pkg::RSP_PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The occupancy never passes the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= nvcrw_pkg::RSP_CNT_BITS'(nvcrw_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // Words are pushed only when two free slots are guaranteed.
   assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> count_ff <= nvcrw_pkg::RSP_ROOM_LIMIT)
      else $error("push into result queue without room");

endmodule

[sv/nonvolatile_changed_run_writer_unit.sv]
// Top level of the nonvolatile changed-run writer.
// An accepted word waits in the input register until the result queue has room.
// Throughput: one input word per cycle while the result side keeps up.
// A word yields at most two results; a four-entry queue sends one per unstalled cycle.
// Synchronous reset clears the update state, the input valid flag and the result queue.
// After reset the block accepts input at once; no clearing pass is needed.
`timescale 1ns / 1ps

module nonvolatile_changed_run_writer_unit #(
   parameter int CHUNK_BYTES  = 64,
   parameter int ADDRESS_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nvcrw_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nvcrw_pkg::rsp_type rsp_word
);

   logic               in_valid_ff, in_valid_in;
   nvcrw_pkg::req_type in_word_ff;
   logic               room;
   logic               advance;
   logic               accept;
   nvcrw_pkg::push_type push;

   always_comb begin
      advance     = in_valid_ff && room;
      req_stall   = in_valid_ff && !room;
      accept      = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   nvcrw_core #(
      .CHUNK_BYTES  (CHUNK_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .item  (in_word_ff),
      .push  (push)
   );

   nvcrw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
